>>> sv/u8tw_pkg.sv
package u8tw_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int WIDTH_BITS  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int GLYPH_W     = 8;
    localparam int CP_W        = 31;
    localparam int CONT_W      = 3;
    localparam int TOTAL_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 24;

    localparam logic REQ_TABLE = 1'b0;
    localparam logic REQ_TEXT  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UTF8  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TILDE = 2'd2;

    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    localparam logic [CP_W-1:0] TILDE_CP  = 31'h7E;
    localparam logic [CP_W-1:0] CP_OFFSET = 31'd32;

    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};

    // one accepted text item as seen by the accumulate stage
    typedef struct packed {
        logic                valid;
        logic                add;
        logic                last;
        logic [STATUS_W-1:0] status;
    } dec_evt_t;

endpackage

>>> sv/u8tw_ram.sv
module u8tw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/u8tw_decode.sv
module u8tw_decode (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      req_type,
    input  logic [7:0]                text_byte,
    input  logic                      last_byte,
    output u8tw_pkg::dec_evt_t        evt,
    output logic [u8tw_pkg::IDX_W-1:0] rd_idx
);

    logic [u8tw_pkg::CONT_W-1:0]   cont_reg,   cont_next;
    logic [u8tw_pkg::CP_W-1:0]     accum_reg,  accum_next;
    logic                          tilde_reg,  tilde_next;
    logic                          hidden_reg, hidden_next;
    logic [u8tw_pkg::STATUS_W-1:0] stop_reg,   stop_next;

    logic                      proceed;
    logic                      take;
    logic [u8tw_pkg::CP_W-1:0] cp_take;
    logic [u8tw_pkg::CP_W-1:0] cp;
    logic [u8tw_pkg::CP_W-1:0] cp_off;

    always_comb
    begin
        cont_next   = cont_reg;
        accum_next  = accum_reg;
        tilde_next  = tilde_reg;
        hidden_next = hidden_reg;
        stop_next   = stop_reg;
        proceed     = 1'b0;
        take        = 1'b0;
        cp_take     = '0;
        cp          = '0;
        evt         = '0;

        if (accept && req_type == u8tw_pkg::REQ_TEXT)
        begin
            evt.valid = 1'b1;
            if (stop_reg == u8tw_pkg::STATUS_OK)
            begin
                proceed = 1'b1;
                if (tilde_reg)
                begin
                    tilde_next = 1'b0;
                    if (text_byte == u8tw_pkg::CHAR_LT || text_byte == u8tw_pkg::CHAR_GT)
                    begin
                        hidden_next = 1'b0;
                        proceed     = 1'b0;
                    end
                    else if (text_byte == u8tw_pkg::CHAR_BANG)
                    begin
                        proceed = 1'b0;
                    end
                    else if (text_byte == u8tw_pkg::CHAR_TILDE)
                    begin
                        proceed = 1'b0;
                        evt.add = !hidden_reg;
                        cp      = u8tw_pkg::TILDE_CP;
                    end
                    else
                    begin
                        hidden_next = !hidden_reg;
                    end
                end

                if (proceed)
                begin
                    if (cont_reg != '0)
                    begin
                        if (text_byte[7:6] != 2'b10)
                        begin
                            stop_next = u8tw_pkg::STATUS_UTF8;
                        end
                        else
                        begin
                            accum_next = {accum_reg[u8tw_pkg::CP_W-7:0], text_byte[5:0]};
                            cont_next  = cont_reg - 3'd1;
                            if (cont_reg == 3'd1)
                            begin
                                take    = 1'b1;
                                cp_take = accum_next;
                            end
                        end
                    end
                    else if (!text_byte[7])
                    begin
                        take    = 1'b1;
                        cp_take = u8tw_pkg::CP_W'(text_byte);
                    end
                    else if (text_byte[7:5] == 3'b110)
                    begin
                        accum_next = u8tw_pkg::CP_W'(text_byte[4:0]);
                        cont_next  = 3'd1;
                    end
                    else if (text_byte[7:4] == 4'b1110)
                    begin
                        accum_next = u8tw_pkg::CP_W'(text_byte[3:0]);
                        cont_next  = 3'd2;
                    end
                    else if (text_byte[7:3] == 5'b11110)
                    begin
                        accum_next = u8tw_pkg::CP_W'(text_byte[2:0]);
                        cont_next  = 3'd3;
                    end
                    else if (text_byte[7:2] == 6'b111110)
                    begin
                        accum_next = u8tw_pkg::CP_W'(text_byte[1:0]);
                        cont_next  = 3'd4;
                    end
                    else if (text_byte[7:1] == 7'b1111110)
                    begin
                        accum_next = u8tw_pkg::CP_W'(text_byte[0]);
                        cont_next  = 3'd5;
                    end
                    else
                    begin
                        stop_next = u8tw_pkg::STATUS_UTF8;
                    end

                    if (take)
                    begin
                        if (cp_take == u8tw_pkg::TILDE_CP)
                        begin
                            tilde_next = 1'b1;
                        end
                        else
                        begin
                            evt.add = !hidden_next;
                            cp      = cp_take;
                        end
                    end
                end
            end

            if (last_byte)
            begin
                evt.last   = 1'b1;
                evt.status = stop_next;
                if (stop_next == u8tw_pkg::STATUS_OK)
                begin
                    if (cont_next != '0)
                    begin
                        evt.status = u8tw_pkg::STATUS_UTF8;
                    end
                    else if (tilde_next)
                    begin
                        evt.status = u8tw_pkg::STATUS_TILDE;
                    end
                end
                cont_next   = '0;
                accum_next  = '0;
                tilde_next  = 1'b0;
                hidden_next = 1'b0;
                stop_next   = u8tw_pkg::STATUS_OK;
            end
        end
    end

    // code points below space or past the table fall back to entry 0
    always_comb
    begin
        cp_off = cp - u8tw_pkg::CP_OFFSET;
        if (cp >= u8tw_pkg::CP_OFFSET && 32'(cp_off) < u8tw_pkg::TABLE_DEPTH)
        begin
            rd_idx = u8tw_pkg::IDX_W'(cp_off);
        end
        else
        begin
            rd_idx = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_reg   <= '0;
            accum_reg  <= '0;
            tilde_reg  <= 1'b0;
            hidden_reg <= 1'b0;
            stop_reg   <= u8tw_pkg::STATUS_OK;
        end
        else
        begin
            cont_reg   <= cont_next;
            accum_reg  <= accum_next;
            tilde_reg  <= tilde_next;
            hidden_reg <= hidden_next;
            stop_reg   <= stop_next;
        end
    end

endmodule

>>> sv/u8tw_accum.sv
module u8tw_accum (
    input  logic                           clk,
    input  logic                           rst_n,
    input  u8tw_pkg::dec_evt_t             evt,
    input  logic [u8tw_pkg::GLYPH_W-1:0]   rd_data,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [u8tw_pkg::TOTAL_W-1:0]   total_width,
    output logic [u8tw_pkg::STATUS_W-1:0]  status
);

    logic                            s1_valid_reg, s1_valid_next;
    logic                            s1_add_reg;
    logic                            s1_last_reg;
    logic [u8tw_pkg::STATUS_W-1:0]   s1_status_reg;
    logic [u8tw_pkg::WIDTH_BITS-1:0] sum_reg, sum_next;
    logic                            out_valid_reg, out_valid_next;
    logic [u8tw_pkg::TOTAL_W-1:0]    total_reg;
    logic [u8tw_pkg::STATUS_W-1:0]   status_reg;

    logic                            s1_move;
    logic [u8tw_pkg::WIDTH_BITS:0]   incr;
    logic [u8tw_pkg::WIDTH_BITS:0]   sum_wide;
    logic [u8tw_pkg::WIDTH_BITS-1:0] sum_sat;

    assign s1_move  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;

    // ram data lines up with stage 1 and holds while it stalls (no new read)
    always_comb
    begin
        incr     = s1_add_reg ? ((u8tw_pkg::WIDTH_BITS+1)'(rd_data) + 1'b1) : '0;
        sum_wide = {1'b0, sum_reg} + incr;
        sum_sat  = sum_wide[u8tw_pkg::WIDTH_BITS] ? u8tw_pkg::WIDTH_MAX
                                                   : sum_wide[u8tw_pkg::WIDTH_BITS-1:0];
    end

    always_comb
    begin
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            if (s1_last_reg)
            begin
                sum_next       = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                sum_next = sum_sat;
            end
        end
        if (evt.valid)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid)
        begin
            s1_add_reg    <= evt.add;
            s1_last_reg   <= evt.last;
            s1_status_reg <= evt.status;
        end
        if (s1_move && s1_last_reg)
        begin
            total_reg  <= u8tw_pkg::TOTAL_W'(sum_sat);
            status_reg <= s1_status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign total_width = total_reg;
    assign status      = status_reg;

endmodule

>>> sv/utf8_markup_text_width_core.sv
// channel  | dir | signals                          | payload
// ---------+-----+----------------------------------+----------------------------------------
// s_axis   | in  | s_tvalid s_tready s_tdata s_tuser | tdata: text_byte, table_index,
//          |     | s_tlast                          |   table_width; tuser: req_type;
//          |     |                                  |   tlast: last_byte
// m_axis   | out | m_tvalid m_tready m_tdata        | tdata: total_width, status
//
// One item per cycle while s_tready is high; the decode state registers and the
// glyph RAM read port each take one item a cycle. The RAM read shares the edge that
// accepts the last byte into stage 1; from there the glyph is added and the result
// registered in the output register, which raises m_tvalid.
// rst_n clears decode state, the running sum and both valid flags; the glyph
// table is not cleared. s_tready drops only while a finished result waits in
// the output register and another last byte waits behind it.
module utf8_markup_text_width_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [u8tw_pkg::S_DATA_W-1:0]   s_tdata,   // text_byte, table_index, table_width
    input  logic                            s_tuser,   // req_type
    input  logic                            s_tlast,   // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [u8tw_pkg::M_DATA_W-1:0]   m_tdata    // total_width, status, zero pad
);

    logic                              accept;
    u8tw_pkg::dec_evt_t                evt;
    logic [u8tw_pkg::IDX_W-1:0]        rd_idx;
    logic                              rd_en;
    logic [u8tw_pkg::GLYPH_W-1:0]      rd_data;
    logic                              wr_en;
    logic [u8tw_pkg::TOTAL_W-1:0]      total_width;
    logic [u8tw_pkg::STATUS_W-1:0]     status;

    assign accept = s_tvalid && s_tready;
    assign wr_en  = accept && s_tuser == u8tw_pkg::REQ_TABLE
                    && 32'(s_tdata[15:8]) < u8tw_pkg::TABLE_DEPTH;
    assign rd_en  = evt.valid && evt.add;

    u8tw_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (s_tuser),
        .text_byte (s_tdata[7:0]),
        .last_byte (s_tlast),
        .evt       (evt),
        .rd_idx    (rd_idx)
    );

    // write and read never share a cycle: one item per edge
    u8tw_ram #(
        .WIDTH (u8tw_pkg::GLYPH_W),
        .DEPTH (u8tw_pkg::TABLE_DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (u8tw_pkg::IDX_W'(s_tdata[15:8])),
        .wdata (s_tdata[23:16]),
        .re    (rd_en),
        .raddr (rd_idx),
        .rdata (rd_data)
    );

    u8tw_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .rd_data     (rd_data),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .total_width (total_width),
        .status      (status)
    );

    assign m_tdata = {{(u8tw_pkg::M_DATA_W - u8tw_pkg::TOTAL_W - u8tw_pkg::STATUS_W){1'b0}},
                      status, total_width};

    a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status == u8tw_pkg::STATUS_OK || status == u8tw_pkg::STATUS_UTF8
                      || status == u8tw_pkg::STATUS_TILDE))
        else $error("result status out of range");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    a_read_source : assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (accept && s_tuser == u8tw_pkg::REQ_TEXT && !wr_en))
        else $error("glyph read without an accepted text item");

    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == u8tw_pkg::REQ_TEXT && s_tlast) |=> ##1 m_tvalid)
        else $error("last byte gave no result");

endmodule
